[rtl/sfr_pkg.sv]
// Shared types, constants and the CRC-32 byte update for the sync frame receiver.
package sfr_pkg;

  // Frame format constants
  localparam int unsigned MAX_PAYLOAD = 128;
  localparam int unsigned HEAD_BYTES  = 12;
  localparam int unsigned HEAD_W      = HEAD_BYTES * 8;
  localparam int unsigned CRC_BYTES   = 4;
  localparam int unsigned CNT_W       = 8;

  localparam logic [7:0]  SYNC_A        = 8'hAA;
  localparam logic [7:0]  SYNC_B        = 8'h55;
  localparam logic [7:0]  CMD_TUNE      = 8'h75;  // 'u'
  localparam logic [7:0]  CMD_ACTION    = 8'h61;  // 'a'
  localparam logic [7:0]  ACT_BYTE_START = 8'h01;
  localparam logic [7:0]  ACT_BYTE_STOP  = 8'h02;
  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY_REFL = 32'hEDB8_8320;  // 0x04C11DB7 reflected

  // Queue between parser and result formatter
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Output stream width, rounded up to whole bytes
  localparam int unsigned RES_BITS = 2 + 8 + 8 + 16 + 2 + 1 + 32 * 4;
  localparam int unsigned RES_W    = ((RES_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_SYNC = 3'd1,
    PH_CMD  = 3'd2,
    PH_SEQ  = 3'd3,
    PH_LENH = 3'd4,
    PH_LENL = 3'd5,
    PH_PAY  = 3'd6,
    PH_CRC  = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_LEN_ERR = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_START   = 2'd1,
    ACT_STOP    = 2'd2,
    ACT_UNKNOWN = 2'd3
  } action_t;

  // One finished frame as handed from the parser to the formatter
  typedef struct packed {
    status_t            status;
    logic [7:0]         cmd;
    logic [7:0]         seq;
    logic [15:0]        len;
    logic [HEAD_W-1:0]  head;   // payload byte i at bits [8i+7:8i]
    logic [31:0]        crc;
  } frame_rec_t;

  // Reflected CRC-32 update by one byte, eight bit steps
  function automatic logic [31:0] crc_feed(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY_REFL) : (r >> 1);
    end
    return r;
  endfunction

endpackage

[rtl/sfr_front.sv]
// Byte parser: sync hunt, header capture, running CRC and frame-end record.
module sfr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] rx_byte
  input  logic              q_full,
  output logic              push,
  output sfr_pkg::frame_rec_t push_rec
);
  import sfr_pkg::*;

  phase_t             phase, phase_next;
  logic [7:0]         cmd_reg;
  logic [7:0]         seq_reg;
  logic [15:0]        len_reg;
  logic [CNT_W-1:0]   count;
  logic [31:0]        crc_running;
  logic [31:0]        crc_captured;
  logic [7:0]         head [HEAD_BYTES];

  logic               accept;
  logic [7:0]         b;
  logic [15:0]        len_full;
  logic               len_bad;
  logic [CNT_W-1:0]   count_inc;
  logic               pay_last;
  logic               crc_last;
  logic [31:0]        crc_in;
  logic [31:0]        crc_nxt;
  logic [31:0]        cap_next;
  logic [HEAD_W-1:0]  head_flat;

  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;
  assign b         = s_tdata;
  assign len_full  = {len_reg[15:8], b};
  assign len_bad   = len_full > 16'(MAX_PAYLOAD);
  assign count_inc = count + CNT_W'(1);
  assign pay_last  = {{(16-CNT_W){1'b0}}, count_inc} >= len_reg;
  assign crc_last  = count == CNT_W'(CRC_BYTES - 1);
  assign crc_in    = (phase == PH_CMD) ? CRC_INIT : crc_running;
  assign crc_nxt   = crc_feed(crc_in, b);
  assign cap_next  = {crc_captured[23:0], b};

  always_comb begin
    for (int i = 0; i < HEAD_BYTES; i++) begin
      head_flat[i*8 +: 8] = head[i];
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        PH_IDLE: phase_next = (b == SYNC_A) ? PH_SYNC : PH_IDLE;
        PH_SYNC: phase_next = (b == SYNC_B) ? PH_CMD : PH_IDLE;
        PH_CMD:  phase_next = PH_SEQ;
        PH_SEQ:  phase_next = PH_LENH;
        PH_LENH: phase_next = PH_LENL;
        PH_LENL: begin
          if (len_bad) phase_next = PH_IDLE;
          else if (len_full != 16'd0) phase_next = PH_PAY;
          else phase_next = PH_CRC;
        end
        PH_PAY:  phase_next = pay_last ? PH_CRC : PH_PAY;
        PH_CRC:  phase_next = crc_last ? PH_IDLE : PH_CRC;
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // Frame-end record towards the queue
  always_comb begin
    push            = accept && (((phase == PH_LENL) && len_bad) ||
                                 ((phase == PH_CRC) && crc_last));
    push_rec.cmd    = cmd_reg;
    push_rec.seq    = seq_reg;
    push_rec.head   = head_flat;
    if (phase == PH_LENL) begin
      push_rec.status = ST_LEN_ERR;
      push_rec.len    = len_full;
      push_rec.crc    = 32'd0;
    end else begin
      push_rec.status = (~crc_running == cap_next) ? ST_OK : ST_CRC_ERR;
      push_rec.len    = len_reg;
      push_rec.crc    = cap_next;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      count <= '0;
    end else begin
      phase <= phase_next;
      if (accept) begin
        unique case (phase)
          PH_LENL: count <= '0;
          PH_PAY:  count <= pay_last ? '0 : count_inc;
          PH_CRC:  count <= crc_last ? '0 : count_inc;
          default: count <= count;
        endcase
      end
    end
  end

  // Header, payload head and CRC capture
  always_ff @(posedge clk) begin
    if (accept) begin
      unique case (phase)
        PH_SYNC: begin
          if (b == SYNC_B) begin
            for (int i = 0; i < HEAD_BYTES; i++) head[i] <= 8'd0;
          end
        end
        PH_CMD: begin
          cmd_reg     <= b;
          crc_running <= crc_nxt;
        end
        PH_SEQ: begin
          seq_reg     <= b;
          crc_running <= crc_nxt;
        end
        PH_LENH: begin
          len_reg     <= {b, 8'd0};
          crc_running <= crc_nxt;
        end
        PH_LENL: begin
          len_reg      <= len_full;
          crc_running  <= crc_nxt;
          crc_captured <= 32'd0;
        end
        PH_PAY: begin
          for (int i = 0; i < HEAD_BYTES; i++) begin
            if (count == CNT_W'(i)) head[i] <= b;
          end
          crc_running <= crc_nxt;
          if (pay_last) crc_captured <= 32'd0;
        end
        PH_CRC: crc_captured <= cap_next;
        default: ;
      endcase
    end
  end

  // Payload counter stays below the declared length
  a_pay_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAY) |-> ({{(16-CNT_W){1'b0}}, count} < len_reg))
    else $error("payload count reached declared length");

  // CRC trailer counter stays within four bytes
  a_crc_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_CRC) |-> (count < CNT_W'(CRC_BYTES)))
    else $error("CRC byte counter out of range");

endmodule

[rtl/sfr_queue.sv]
// Short FIFO of frame records between the parser and the result formatter.
module sfr_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sfr_pkg::frame_rec_t push_rec,
  output logic                full,
  output logic                q_valid,
  input  logic                pop,
  output sfr_pkg::frame_rec_t q_rec
);
  import sfr_pkg::*;

  frame_rec_t        mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = count == QCNT_W'(QUEUE_DEPTH);
  assign q_valid = count != '0;
  assign q_rec   = mem[rd_ptr];

  // Store records
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_rec;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("record pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !q_valid))
    else $error("record popped from empty queue");

endmodule

[rtl/sfr_back.sv]
// Result formatter: decodes action and gain words and drives the output register.
module sfr_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  sfr_pkg::frame_rec_t        q_rec,
  output logic                       pop,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [sfr_pkg::RES_W-1:0]  m_tdata
);
  import sfr_pkg::*;

  logic                 load;
  logic                 crc_ok;
  action_t              action;
  logic                 tuning_valid;
  logic [31:0]          gain_p;
  logic [31:0]          gain_i;
  logic [31:0]          gain_d;
  logic [RES_BITS-1:0]  res;

  assign load   = !m_tvalid || m_tready;
  assign pop    = q_valid && load;
  assign crc_ok = q_rec.status == ST_OK;

  // Decode the command
  always_comb begin
    action       = ACT_NONE;
    tuning_valid = 1'b0;
    gain_p       = 32'd0;
    gain_i       = 32'd0;
    gain_d       = 32'd0;
    if (crc_ok && (q_rec.cmd == CMD_ACTION)) begin
      if (q_rec.head[7:0] == ACT_BYTE_START) action = ACT_START;
      else if (q_rec.head[7:0] == ACT_BYTE_STOP) action = ACT_STOP;
      else action = ACT_UNKNOWN;
    end else if (crc_ok && (q_rec.cmd == CMD_TUNE)) begin
      tuning_valid = 1'b1;
      gain_p       = q_rec.head[31:0];
      gain_i       = q_rec.head[63:32];
      gain_d       = q_rec.head[95:64];
    end
  end

  assign res = {q_rec.crc, gain_d, gain_i, gain_p, tuning_valid, action,
                q_rec.len, q_rec.seq, q_rec.cmd, q_rec.status};

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= q_valid;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (pop) m_tdata <= RES_W'(res);
  end

  a_tune_needs_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[36]) |-> (m_tdata[1:0] == ST_OK))
    else $error("gains delivered without a good CRC");

  a_action_needs_cmd: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[35:34] != ACT_NONE)) |->
      ((m_tdata[9:2] == CMD_ACTION) && (m_tdata[1:0] == ST_OK) && !m_tdata[36]))
    else $error("action reported for a frame that is not a good action frame");

endmodule

[rtl/sync_frame_receiver_crc32.sv]
// A frame's record is pushed into the queue when the request with the last CRC byte
//   (or low length byte of an oversized frame) is accepted; then it is registered out.
// One byte per cycle while the queue is not full; the per-byte CRC update sets the path.
// The parser and formatter are parted by a two-entry record queue and an output register.
// Reset (rst, synchronous, active high) returns the parser to sync hunting and empties
//   the queue and output register.
module sync_frame_receiver_crc32 (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // [7:0] rx_byte
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // [1:0] frame_status, [9:2] cmd_byte, [17:10] frame_seq, [33:18] length_field,
  // [35:34] action_code, [36] tuning_valid, [68:37] gain_p_bits,
  // [100:69] gain_i_bits, [132:101] gain_d_bits, [164:133] crc_received, rest zero
  output logic [sfr_pkg::RES_W-1:0]  m_tdata
);
  import sfr_pkg::*;

  logic       push;
  frame_rec_t push_rec;
  logic       q_full;
  logic       q_valid;
  logic       pop;
  frame_rec_t q_rec;

  sfr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  sfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .q_valid  (q_valid),
    .pop      (pop),
    .q_rec    (q_rec)
  );

  sfr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_rec    (q_rec),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
